[rtl/lfst_pkg.sv]
// shared types and constants for the fetch slot table
// no dependencies; imported by the interfaces and every module
`default_nettype none

package lfst_pkg;

  localparam int KEY_W   = 32;
  localparam int TIME_W  = 48;
  localparam int RETRY_W = 20;
  localparam int IDX_W   = 3;

  localparam logic [RETRY_W-1:0] RETRY_RESET = 20'd60000;

  typedef enum logic [1:0] {
    OP_REQUEST  = 2'd0,
    OP_TAKE     = 2'd1,
    OP_DISPATCH = 2'd2,
    OP_COMPLETE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_MISS    = 2'd1,
    ST_BAD_KEY = 2'd2,
    ST_IGNORED = 2'd3
  } stat_t;

  typedef enum logic [2:0] {
    PH_EMPTY     = 3'd0,
    PH_QUEUED    = 3'd1,
    PH_LOADING   = 3'd2,
    PH_READY     = 3'd3,
    PH_DELIVERED = 3'd4,
    PH_FAILED    = 3'd5
  } phase_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    phase_t            phase;
    logic [TIME_W-1:0] touched;
    logic [TIME_W-1:0] retry_at;
  } slot_rec_t;

  // verdict of the shared compare unit on one slot
  typedef struct packed {
    logic hit;
    logic better;
  } eval_t;

endpackage

`default_nettype wire

[rtl/lfst_ifs.sv]
// channel interfaces of the fetch slot table: request, response, config
// depends on lfst_pkg for field widths
`default_nettype none

interface lfst_req_if import lfst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [KEY_W-1:0]  key;
  logic [TIME_W-1:0] now_ms;
  logic [IDX_W-1:0]  slot_index;
  logic              load_ok;
  logic              was_cancelled;

  modport source (output valid, opcode, key, now_ms, slot_index, load_ok, was_cancelled,
                  input ready);
  modport sink (input valid, opcode, key, now_ms, slot_index, load_ok, was_cancelled,
                output ready);
endinterface

interface lfst_rsp_if import lfst_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [IDX_W-1:0] hit_slot;
  logic [KEY_W-1:0] hit_key;
  logic             newly_queued;
  logic             was_evicted;

  modport source (output valid, status, hit_slot, hit_key, newly_queued, was_evicted,
                  input ready);
  modport sink (input valid, status, hit_slot, hit_key, newly_queued, was_evicted,
                output ready);
endinterface

interface lfst_cfg_if import lfst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RETRY_W-1:0] retry_interval;

  modport source (output valid, retry_interval, input ready);
  modport sink (input valid, retry_interval, output ready);
endinterface

`default_nettype wire

[rtl/lfst_slot_eval.sv]
// shared compare unit: judges one slot record per cycle for the current op
// depends on lfst_pkg
`default_nettype none

module lfst_slot_eval import lfst_pkg::*; #(
  parameter int SLOT_W = 3
) (
  input  op_t               op,
  input  logic [KEY_W-1:0]  key,
  input  logic [IDX_W-1:0]  slot_index,
  input  logic [SLOT_W-1:0] slot,
  input  slot_rec_t         rec,
  input  logic              cand_valid,
  input  logic [TIME_W-1:0] cand_touched,
  output eval_t             verdict
);

  localparam int CW = (SLOT_W > IDX_W) ? SLOT_W : IDX_W;

  logic key_eq;
  logic idx_eq;
  logic older;

  assign key_eq = (rec.key == key);
  assign idx_eq = (CW'(slot) == CW'(slot_index));
  // strict compare keeps the lowest index on a tie
  assign older  = !cand_valid || (rec.touched < cand_touched);

  always_comb begin
    verdict = '0;
    unique case (op)
      OP_REQUEST: begin
        verdict.hit    = key_eq;
        verdict.better = (rec.phase != PH_LOADING) && older;
      end
      OP_TAKE:     verdict.hit = key_eq && (rec.phase == PH_READY);
      OP_DISPATCH: verdict.hit = (rec.phase == PH_QUEUED);
      OP_COMPLETE: verdict.hit = idx_eq;
      default:     verdict = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/lru_fetch_slot_table.sv]
// Fetch slot table: SLOTS keyed slots kept in one record memory and walked one slot per
// cycle through a single shared compare unit. From one accept to the next an item passes
// through the idle state, the scan state once per slot read, the tail state for the last
// read to return, and the update state that writes the slot back and loads the response
// register; a request with a zero key skips the walk. The walk runs over the memory's
// single read port. The response register holds a finished result, so the next item is
// accepted while it waits; a new update waits only if it is still unread. Slot state
// reads as empty after reset through per-slot valid flops, so no clearing pass is
// needed. hit_slot carries the low three bits of the slot number.
`default_nettype none

module lru_fetch_slot_table import lfst_pkg::*; #(
  parameter int SLOTS = 8
) (
  input wire logic       clk,
  input wire logic       rst,
  lfst_req_if.sink       req,
  lfst_rsp_if.source     rsp,
  lfst_cfg_if.sink       cfg
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = (SW > IDX_W) ? SW : IDX_W;
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_UPDATE
  } state_t;

  state_t state;

  // captured item
  op_t               op_q;
  logic [KEY_W-1:0]  key_q;
  logic [TIME_W-1:0] now_q;
  logic [IDX_W-1:0]  idx_q;
  logic              ok_q;
  logic              canc_q;

  logic [RETRY_W-1:0] retry_interval;

  // slot memory
  slot_rec_t        mem [SLOTS];
  logic [SLOTS-1:0] mem_valid;
  slot_rec_t        rd_rec;
  logic             rd_vld;
  logic [SW-1:0]    scan_addr;
  logic             rd_live;
  logic [SW-1:0]    rd_idx;
  slot_rec_t        seen;

  // walk results
  logic          found;
  logic [SW-1:0] hit_idx;
  slot_rec_t     hit_rec;
  logic          cand;
  logic [SW-1:0] cand_idx;
  slot_rec_t     cand_rec;
  eval_t         verdict;

  // response register
  logic             rsp_valid;
  stat_t            rsp_status;
  logic [IDX_W-1:0] rsp_slot;
  logic [KEY_W-1:0] rsp_key;
  logic             rsp_queued;
  logic             rsp_evicted;

  // update cycle
  logic              out_free;
  logic              commit;
  logic              wr_en;
  logic [SW-1:0]     wr_idx;
  slot_rec_t         wr_rec;
  stat_t             res_status;
  logic [KEY_W-1:0]  res_key;
  logic              res_queued;
  logic              res_evicted;
  logic [TIME_W:0]   retry_sum;
  logic [TIME_W-1:0] retry_sat;
  logic [CW-1:0]     wr_idx_ext;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_status;
  assign rsp.hit_slot     = rsp_slot;
  assign rsp.hit_key      = rsp_key;
  assign rsp.newly_queued = rsp_queued;
  assign rsp.was_evicted  = rsp_evicted;

  assign out_free = !rsp_valid || rsp.ready;
  assign commit   = (state == S_UPDATE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_interval <= RETRY_RESET;
    end else if (cfg.valid) begin
      retry_interval <= cfg.retry_interval;
    end
  end

  always_ff @(posedge clk) begin
    rd_rec <= mem[scan_addr];
    rd_vld <= mem_valid[scan_addr];
    if (commit && wr_en) begin
      mem[wr_idx] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_valid <= '0;
    end else if (commit && wr_en) begin
      mem_valid[wr_idx] <= 1'b1;
    end
  end

  // never-written slots read as the reset record
  assign seen = rd_vld ? rd_rec : '0;

  lfst_slot_eval #(
    .SLOT_W (SW)
  ) u_eval (
    .op           (op_q),
    .key          (key_q),
    .slot_index   (idx_q),
    .slot         (rd_idx),
    .rec          (seen),
    .cand_valid   (cand),
    .cand_touched (cand_rec.touched),
    .verdict      (verdict)
  );

  assign retry_sum  = {1'b0, now_q} + (TIME_W + 1)'(retry_interval);
  assign retry_sat  = retry_sum[TIME_W] ? '1 : retry_sum[TIME_W-1:0];
  assign wr_idx_ext = CW'(wr_idx);

  always_comb begin
    wr_en       = 1'b0;
    wr_idx      = hit_idx;
    wr_rec      = hit_rec;
    res_status  = ST_MISS;
    res_key     = '0;
    res_queued  = 1'b0;
    res_evicted = 1'b0;
    unique case (op_q)
      OP_REQUEST: begin
        if (key_q == '0) begin
          res_status = ST_BAD_KEY;
        end else if (found || cand) begin
          if (!found) begin
            wr_idx          = cand_idx;
            wr_rec          = cand_rec;
            res_evicted     = (cand_rec.key != '0);
            wr_rec.key      = key_q;
            wr_rec.phase    = PH_EMPTY;
            wr_rec.retry_at = '0;
          end
          wr_rec.touched = now_q;
          if (wr_rec.phase == PH_EMPTY || wr_rec.phase == PH_DELIVERED ||
              (wr_rec.phase == PH_FAILED && now_q >= wr_rec.retry_at)) begin
            wr_rec.phase = PH_QUEUED;
            res_queued   = 1'b1;
          end
          wr_en      = 1'b1;
          res_status = ST_DONE;
          res_key    = key_q;
        end
      end
      OP_TAKE: begin
        if (found) begin
          wr_rec.phase = PH_DELIVERED;
          wr_en        = 1'b1;
          res_status   = ST_DONE;
          res_key      = key_q;
        end
      end
      OP_DISPATCH: begin
        if (found) begin
          wr_rec.phase = PH_LOADING;
          wr_en        = 1'b1;
          res_status   = ST_DONE;
          res_key      = hit_rec.key;
        end
      end
      OP_COMPLETE: begin
        if (found && hit_rec.phase == PH_LOADING) begin
          if (ok_q) begin
            wr_rec.phase = PH_READY;
          end else begin
            wr_rec.phase    = canc_q ? PH_QUEUED : PH_FAILED;
            wr_rec.retry_at = retry_sat;
          end
          wr_en      = 1'b1;
          res_status = ST_DONE;
          res_key    = hit_rec.key;
        end else begin
          res_status = ST_IGNORED;
        end
      end
      default: res_status = ST_MISS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_live   <= 1'b0;
      found     <= 1'b0;
      cand      <= 1'b0;
      rsp_valid <= 1'b0;
      scan_addr <= '0;
    end else begin
      rd_live <= (state == S_SCAN);
      rd_idx  <= scan_addr;
      if (rd_live) begin
        if (verdict.hit && !found) begin
          found   <= 1'b1;
          hit_idx <= rd_idx;
          hit_rec <= seen;
        end
        if (verdict.better) begin
          cand     <= 1'b1;
          cand_idx <= rd_idx;
          cand_rec <= seen;
        end
      end
      if (rsp_valid && rsp.ready && !commit) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_q      <= op_t'(req.opcode);
            key_q     <= req.key;
            now_q     <= req.now_ms;
            idx_q     <= req.slot_index;
            ok_q      <= req.load_ok;
            canc_q    <= req.was_cancelled;
            found     <= 1'b0;
            cand      <= 1'b0;
            scan_addr <= '0;
            // zero key on a request needs no walk
            if (op_t'(req.opcode) == OP_REQUEST && req.key == '0) begin
              state <= S_UPDATE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_addr == LAST_SLOT) begin
            state <= S_TAIL;
          end else begin
            scan_addr <= scan_addr + 1'b1;
          end
        end
        S_TAIL: state <= S_UPDATE;
        S_UPDATE: begin
          if (out_free) begin
            rsp_valid   <= 1'b1;
            rsp_status  <= res_status;
            rsp_slot    <= (res_status == ST_DONE) ? wr_idx_ext[IDX_W-1:0] : '0;
            rsp_key     <= res_key;
            rsp_queued  <= res_queued;
            rsp_evicted <= res_evicted;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_fail_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status != ST_DONE) |-> (rsp_slot == '0 && rsp_key == '0 &&
                                              !rsp_queued && !rsp_evicted))
    else $error("non-done result carries slot data");

  a_flags_request_only: assert property (@(posedge clk) disable iff (rst)
    (commit && op_q != OP_REQUEST) |=> (!rsp_queued && !rsp_evicted))
    else $error("queue or evict flag on a non-request result");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("accepted a second item before the walk");

  a_read_in_walk: assert property (@(posedge clk) disable iff (rst)
    rd_live |-> (state == S_SCAN || state == S_TAIL))
    else $error("read data returned outside the walk");

  a_write_keeps_result: assert property (@(posedge clk) disable iff (rst)
    (commit && wr_en) |=> (rsp_valid && rsp_status == ST_DONE))
    else $error("slot written without a done result");

endmodule

`default_nettype wire
